/* hw/rtl/tiny_8bit_cpu_core_assert.svh */
// Assertion macros shared by the CPU core RTL.
`ifndef TINY_8BIT_CPU_CORE_ASSERT_SVH
`define TINY_8BIT_CPU_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define T8C_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in the CPU core");

// The consequent must hold in the cycle after the antecedent.
`define T8C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in the CPU core");

`endif

/* hw/rtl/t8c_pkg.sv */
// Package with the constants, codes and types of the CPU core.
package t8c_pkg;

   localparam int MemDepth = 256;
   localparam int AddrW    = $clog2(MemDepth);

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   localparam logic [7:0] OP_NOP   = 8'd0;
   localparam logic [7:0] OP_STA   = 8'd1;
   localparam logic [7:0] OP_STX   = 8'd2;
   localparam logic [7:0] OP_STY   = 8'd3;
   localparam logic [7:0] OP_LDXI  = 8'd4;
   localparam logic [7:0] OP_LDX   = 8'd5;
   localparam logic [7:0] OP_LDY   = 8'd6;
   localparam logic [7:0] OP_TAX   = 8'd7;
   localparam logic [7:0] OP_ADD   = 8'd8;
   localparam logic [7:0] OP_SUB   = 8'd9;
   localparam logic [7:0] OP_CMP   = 8'd10;
   localparam logic [7:0] OP_AND   = 8'd11;
   localparam logic [7:0] OP_OR    = 8'd12;
   localparam logic [7:0] OP_JMP   = 8'd14;
   localparam logic [7:0] OP_BRZ   = 8'd15;

   localparam logic [7:0]  HaltArg = 8'hFF;
   localparam logic [15:0] PcStep  = 16'd2;

   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] pc;
      logic        zero;
      logic        halted;
      logic        execute_next;
      logic [15:0] instr;
   } cpu_state_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } mem_wr_type;

endpackage

/* hw/rtl/t8c_ram.sv */
// Byte RAM with two registered read ports, one write port and per-entry valid bits.
module t8c_ram import t8c_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [15:0] rd_addr_a,
   input  logic [15:0] rd_addr_b,
   input  mem_wr_type  wr,
   output logic [7:0]  rd_data_a,
   output logic [7:0]  rd_data_b
);

   logic [7:0]          ram_ff [MemDepth];
   logic [MemDepth-1:0] valid_ff;
   logic [7:0]          rd_a_ff;
   logic [7:0]          rd_b_ff;
   logic                wr_ok;
   logic                ok_a;
   logic                ok_b;
   logic [AddrW-1:0]    idx_w;
   logic [AddrW-1:0]    idx_a;
   logic [AddrW-1:0]    idx_b;

   assign idx_w = wr.addr[AddrW-1:0];
   assign idx_a = rd_addr_a[AddrW-1:0];
   assign idx_b = rd_addr_b[AddrW-1:0];
   assign wr_ok = wr.en && ({8'd0, wr.addr} < 16'(MemDepth));
   assign ok_a  = rd_addr_a < 16'(MemDepth);
   assign ok_b  = rd_addr_b < 16'(MemDepth);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         ram_ff[idx_w] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ok) begin
         valid_ff[idx_w] <= 1'b1;
      end
   end

   // A write in the same cycle as a read at the same entry is passed through.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (!ok_a) begin
            rd_a_ff <= 8'd0;
         end else if (wr_ok && (idx_w == idx_a)) begin
            rd_a_ff <= wr.data;
         end else if (valid_ff[idx_a]) begin
            rd_a_ff <= ram_ff[idx_a];
         end else begin
            rd_a_ff <= 8'd0;
         end
         if (!ok_b) begin
            rd_b_ff <= 8'd0;
         end else if (wr_ok && (idx_w == idx_b)) begin
            rd_b_ff <= wr.data;
         end else if (valid_ff[idx_b]) begin
            rd_b_ff <= ram_ff[idx_b];
         end else begin
            rd_b_ff <= 8'd0;
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hw/rtl/t8c_exec.sv */
// Next-state logic of the CPU: fetch, instruction execute and host access.
module t8c_exec import t8c_pkg::*; (
   input  logic [1:0]    action,
   input  logic [7:0]    address,
   input  logic [7:0]    write_data,
   input  cpu_state_type cur,
   input  logic [7:0]    rd_data_a,
   input  logic [7:0]    rd_data_b,
   output cpu_state_type nxt,
   output mem_wr_type    wr,
   output logic [7:0]    read_data
);

   logic [7:0] op;
   logic [7:0] arg;
   logic       pc_set;
   logic [7:0] alu;

   assign op  = cur.instr[15:8];
   assign arg = cur.instr[7:0];

   always_comb begin
      nxt       = cur;
      wr        = '0;
      read_data = 8'd0;
      pc_set    = 1'b0;
      alu       = 8'd0;
      unique case (action)
         ACT_TICK: begin
            if (!cur.halted) begin
               if (!cur.execute_next) begin
                  nxt.instr        = {rd_data_a, rd_data_b};
                  nxt.execute_next = 1'b1;
               end else begin
                  nxt.execute_next = 1'b0;
                  case (op)
                     OP_NOP: begin
                        if (arg == HaltArg) begin
                           nxt.halted = 1'b1;
                        end
                     end
                     OP_STA: wr = '{en: 1'b1, addr: arg, data: cur.acc};
                     OP_STX: wr = '{en: 1'b1, addr: arg, data: cur.x};
                     OP_STY: wr = '{en: 1'b1, addr: arg, data: cur.y};
                     OP_LDXI: nxt.x = arg;
                     OP_LDX: nxt.x = rd_data_a;
                     OP_LDY: nxt.y = rd_data_a;
                     OP_TAX: nxt.x = cur.acc;
                     OP_ADD, OP_SUB, OP_AND, OP_OR: begin
                        case (op)
                           OP_ADD:  alu = cur.x + cur.y;
                           OP_SUB:  alu = cur.x - cur.y;
                           OP_AND:  alu = cur.x & cur.y;
                           default: alu = cur.x | cur.y;
                        endcase
                        nxt.acc  = alu;
                        nxt.zero = (alu == 8'd0);
                     end
                     OP_CMP: nxt.zero = (cur.x == cur.y);
                     OP_JMP: begin
                        nxt.pc = {8'd0, arg};
                        pc_set = 1'b1;
                     end
                     OP_BRZ: begin
                        nxt.pc = cur.zero ? {8'd0, arg} : cur.pc + PcStep;
                        pc_set = 1'b1;
                     end
                     default: nxt.halted = 1'b1;
                  endcase
                  if (!pc_set && !nxt.halted) begin
                     nxt.pc = cur.pc + PcStep;
                  end
               end
            end
         end
         ACT_WRITE: wr = '{en: 1'b1, addr: address, data: write_data};
         ACT_READ:  read_data = rd_data_a;
         default: ;
      endcase
   end

endmodule

/* hw/rtl/tiny_8bit_cpu_core.sv */
// Top level of the small 8-bit CPU core with its byte RAM.
//
// Each request word carries an action: a CPU tick, a host RAM write or a
// host RAM read, with an address and write data. Every request gives one
// response word: the byte read (0 unless a host read), followed by the
// halt flag, the phase bit, PC, A, X, Y and the zero flag after the request.
// A fetch tick loads a 16-bit instruction from RAM at PC and PC+1; the next
// tick executes it. Once halted, ticks change nothing.
// The RAM read ports are addressed at acceptance, with the state that the
// request ahead of it is leaving; the read data is registered and the
// request is executed and written back in the execute stage. A write back
// to the entry read in the same cycle is passed through. One request is
// accepted every cycle unless the receiver stalls, limited by the single
// read-modify-write stage. Reset clears the CPU state and valid bits and
// marks every RAM entry as zero; no clearing pass is needed, requests are
// taken from the first cycle after reset. When the receiver stalls, the
// response stays in the output register, the execute stage holds one
// request, and req_stall rises after that.
`include "tiny_8bit_cpu_core_assert.svh"

module tiny_8bit_cpu_core import t8c_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_halted,
   output logic        rsp_execute_next,
   output logic [15:0] rsp_program_counter,
   output logic [7:0]  rsp_accumulator,
   output logic [7:0]  rsp_index_x,
   output logic [7:0]  rsp_index_y,
   output logic        rsp_zero_flag
);

   cpu_state_type st_ff;
   cpu_state_type st_in;
   cpu_state_type st_nxt;
   cpu_state_type out_st_ff;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic [1:0]    s1_action_ff;
   logic [7:0]    s1_address_ff;
   logic [7:0]    s1_write_data_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [7:0]    out_read_data_ff;
   logic          s1_go;
   logic          accept;
   logic          commit;
   logic [15:0]   rd_addr_a;
   logic [15:0]   rd_addr_b;
   logic [7:0]    rd_data_a;
   logic [7:0]    rd_data_b;
   logic [7:0]    read_data;
   mem_wr_type    wr_req;
   mem_wr_type    ram_wr;

   assign s1_go     = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;
   assign commit    = s1_valid_ff && s1_go;

   assign st_in  = commit ? st_nxt : st_ff;
   assign ram_wr = '{en: commit && wr_req.en, addr: wr_req.addr, data: wr_req.data};

   always_comb begin
      rd_addr_a = {8'd0, req_address};
      if (req_action == ACT_TICK) begin
         rd_addr_a = st_in.execute_next ? {8'd0, st_in.instr[7:0]} : st_in.pc;
      end
      rd_addr_b = st_in.pc + 16'd1;
   end

   t8c_ram u_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr        (ram_wr),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   t8c_exec u_exec (
      .action     (s1_action_ff),
      .address    (s1_address_ff),
      .write_data (s1_write_data_ff),
      .cur        (st_ff),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .nxt        (st_nxt),
      .wr         (wr_req),
      .read_data  (read_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (commit) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (commit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff     <= req_action;
         s1_address_ff    <= req_address;
         s1_write_data_ff <= req_write_data;
      end
      if (commit) begin
         out_st_ff        <= st_nxt;
         out_read_data_ff <= read_data;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_read_data       = out_read_data_ff;
   assign rsp_halted          = out_st_ff.halted;
   assign rsp_execute_next    = out_st_ff.execute_next;
   assign rsp_program_counter = out_st_ff.pc;
   assign rsp_accumulator     = out_st_ff.acc;
   assign rsp_index_x         = out_st_ff.x;
   assign rsp_index_y         = out_st_ff.y;
   assign rsp_zero_flag       = out_st_ff.zero;

   `T8C_ASSERT_NEXT(a_halt_sticks, clock, reset, st_ff.halted, st_ff.halted)
   `T8C_ASSERT_NEXT(a_phase_toggles, clock, reset,
      commit && (s1_action_ff == ACT_TICK) && !st_ff.halted,
      st_ff.execute_next != $past(st_ff.execute_next))
   `T8C_ASSERT_SAME(a_full_blocks, clock, reset,
      s1_valid_ff && out_valid_ff && rsp_stall, req_stall && !ram_wr.en)
   `T8C_ASSERT_NEXT(a_commit_gives_rsp, clock, reset, commit, rsp_valid)

endmodule
